@@ hw/rtl/ph16_pkg.sv @@
// Package for the two-lane Pearson hash: byte permutation table and widths.
// No dependencies; imported by pearson_hash_16bit.

package ph16_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned HASH_W = 2 * BYTE_W;
    localparam int unsigned ROM_DEPTH = 1 << BYTE_W;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [HASH_W-1:0] hash_t;

    localparam byte_t PERM_ROM [ROM_DEPTH] = '{
        8'h01, 8'h57, 8'h31, 8'h0c, 8'hb0, 8'hb2, 8'h66, 8'ha6,
        8'h79, 8'hc1, 8'h06, 8'h54, 8'hf9, 8'he6, 8'h2c, 8'ha3,
        8'h0e, 8'hc5, 8'hd5, 8'hb5, 8'ha1, 8'h55, 8'hda, 8'h50,
        8'h40, 8'hef, 8'h18, 8'he2, 8'hec, 8'h8e, 8'h26, 8'hc8,
        8'h6e, 8'hb1, 8'h68, 8'h67, 8'h8d, 8'hfd, 8'hff, 8'h32,
        8'h4d, 8'h65, 8'h51, 8'h12, 8'h2d, 8'h60, 8'h1f, 8'hde,
        8'h19, 8'h6b, 8'hbe, 8'h46, 8'h56, 8'hed, 8'hf0, 8'h22,
        8'h48, 8'hf2, 8'h14, 8'hd6, 8'hf4, 8'he3, 8'h95, 8'heb,
        8'h61, 8'hea, 8'h39, 8'h16, 8'h3c, 8'hfa, 8'h52, 8'haf,
        8'hd0, 8'h05, 8'h7f, 8'hc7, 8'h6f, 8'h3e, 8'h87, 8'hf8,
        8'hae, 8'ha9, 8'hd3, 8'h3a, 8'h42, 8'h9a, 8'h6a, 8'hc3,
        8'hf5, 8'hab, 8'h11, 8'hbb, 8'hb6, 8'hb3, 8'h00, 8'hf3,
        8'h84, 8'h38, 8'h94, 8'h4b, 8'h80, 8'h85, 8'h9e, 8'h64,
        8'h82, 8'h7e, 8'h5b, 8'h0d, 8'h99, 8'hf6, 8'hd8, 8'hdb,
        8'h77, 8'h44, 8'hdf, 8'h4e, 8'h53, 8'h58, 8'hc9, 8'h63,
        8'h7a, 8'h0b, 8'h5c, 8'h20, 8'h88, 8'h72, 8'h34, 8'h0a,
        8'h8a, 8'h1e, 8'h30, 8'hb7, 8'h9c, 8'h23, 8'h3d, 8'h1a,
        8'h8f, 8'h4a, 8'hfb, 8'h5e, 8'h81, 8'ha2, 8'h3f, 8'h98,
        8'haa, 8'h07, 8'h73, 8'ha7, 8'hf1, 8'hce, 8'h03, 8'h96,
        8'h37, 8'h3b, 8'h97, 8'hdc, 8'h5a, 8'h35, 8'h17, 8'h83,
        8'h7d, 8'had, 8'h0f, 8'hee, 8'h4f, 8'h5f, 8'h59, 8'h10,
        8'h69, 8'h89, 8'he1, 8'he0, 8'hd9, 8'ha0, 8'h25, 8'h7b,
        8'h76, 8'h49, 8'h02, 8'h9d, 8'h2e, 8'h74, 8'h09, 8'h91,
        8'h86, 8'he4, 8'hcf, 8'hd4, 8'hca, 8'hd7, 8'h45, 8'he5,
        8'h1b, 8'hbc, 8'h43, 8'h7c, 8'ha8, 8'hfc, 8'h2a, 8'h04,
        8'h1d, 8'h6c, 8'h15, 8'hf7, 8'h13, 8'hcd, 8'h27, 8'hcb,
        8'he9, 8'h28, 8'hba, 8'h93, 8'hc6, 8'hc0, 8'h9b, 8'h21,
        8'ha4, 8'hbf, 8'h62, 8'hcc, 8'ha5, 8'hb4, 8'h75, 8'h4c,
        8'h8c, 8'h24, 8'hd2, 8'hac, 8'h29, 8'h36, 8'h9f, 8'h08,
        8'hb9, 8'he8, 8'h71, 8'hc4, 8'he7, 8'h2f, 8'h92, 8'h78,
        8'h33, 8'h41, 8'h1c, 8'h90, 8'hfe, 8'hdd, 8'h5d, 8'hbd,
        8'hc2, 8'h8b, 8'h70, 8'h2b, 8'h47, 8'h6d, 8'hb8, 8'hd1
    };

endpackage

@@ hw/rtl/pearson_hash_16bit.sv @@
// A result beat is offered in the cycle after the beat that ends its message.
// One byte per cycle while s_ready is high; each lane does a single table lookup per byte,
// and that lookup-and-update loop is combinational into the lane registers.
// A result waiting in the output register does not stop intake while the sink takes it.
// Reset (aresetn low, synchronous): lanes cleared, next byte starts a message,
// zero-terminated mode off, no result pending.

module pearson_hash_16bit
    import ph16_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_data_byte,
    input  logic              s_last_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [HASH_W-1:0] m_hash_value
);

    logic  zero_term_reg;
    logic  start_reg, start_next;
    byte_t lane_one_reg, lane_one_next;
    byte_t lane_two_reg, lane_two_next;
    logic  m_valid_reg, m_valid_next;
    hash_t m_hash_reg, m_hash_next;

    logic  s_beat;
    logic  zero_end;
    byte_t idx_one, idx_two;
    byte_t rom_one, rom_two;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_beat  = s_valid && s_ready;
    assign zero_end = zero_term_reg && (s_data_byte == '0);

    // first byte indexes the table directly, without the lane XOR; lane two indexes one higher, wrapping
    assign idx_one = start_reg ? s_data_byte : (lane_one_reg ^ s_data_byte);
    assign idx_two = start_reg ? byte_t'(s_data_byte + byte_t'(1)) : (lane_two_reg ^ s_data_byte);
    assign rom_one = PERM_ROM[idx_one];
    assign rom_two = PERM_ROM[idx_two];

    always_comb begin
        start_next    = start_reg;
        lane_one_next = lane_one_reg;
        lane_two_next = lane_two_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_hash_next   = m_hash_reg;
        if (s_beat) begin
            if (zero_end) begin
                // terminator: lanes hold, message closes
                m_valid_next = 1'b1;
                m_hash_next  = start_reg ? hash_t'(0) : {lane_two_reg, lane_one_reg};
                start_next   = 1'b1;
            end else begin
                lane_one_next = rom_one;
                lane_two_next = rom_two;
                start_next    = s_last_byte;
                if (s_last_byte) begin
                    m_valid_next = 1'b1;
                    m_hash_next  = {rom_two, rom_one};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_term_reg <= 1'b0;
            start_reg     <= 1'b1;
            lane_one_reg  <= '0;
            lane_two_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                zero_term_reg <= cfg_wr_data;
            end
            start_reg    <= start_next;
            lane_one_reg <= lane_one_next;
            lane_two_reg <= lane_two_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_hash_reg <= m_hash_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_hash_value = m_hash_reg;

    // a terminator as first byte gives a zero hash
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_beat && zero_end && start_reg) |=> (m_valid && (m_hash_value == '0)))
        else $error("empty zero-terminated message did not hash to zero");

    // every message end yields a result beat and rearms the start flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_beat && (s_last_byte || zero_end)) |=> (m_valid && start_reg))
        else $error("message end lost its result or start flag");

    // a hashed middle byte clears the start flag and emits nothing new
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_beat && !s_last_byte && !zero_end) |=> (!start_reg && (m_valid == $past(m_valid && !m_ready))))
        else $error("middle byte disturbed start flag or output");

    // lanes move only on an accepted, hashed byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_beat && !zero_end) |=> ($stable(lane_one_reg) && $stable(lane_two_reg)))
        else $error("lanes changed without a hashed byte");

endmodule
